FILE: design/papt_pkg.sv
// ----------------------------------------------------------------------------
// Page attribute protection table package
// Shared widths, codes, transaction types and state encodings.
// ----------------------------------------------------------------------------
package papt_pkg;

  // Default sizing of the attribute store.
  localparam int unsigned REGION_SLOTS_DEF     = 2;
  localparam int unsigned PAGES_PER_REGION_DEF = 256;

  // Field widths.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned RCOUNT_W   = 2;
  localparam int unsigned RPAGES_W   = 9;
  localparam int unsigned ATTR_W     = 4;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [SHIFT_W-1:0]  PAGE_SHIFT_RST   = 5'd12;
  localparam logic [RCOUNT_W-1:0] REGION_COUNT_RST = 2'd1;

  // Level mask codes.
  localparam logic [LEVEL_W-1:0] LVL_NONE = 2'b00;
  localparam logic [LEVEL_W-1:0] LVL_USER = 2'b01;
  localparam logic [LEVEL_W-1:0] LVL_PRIV = 2'b10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_SHIFT   = 3'd0,
    CFG_REGION_COUNT = 3'd1,
    CFG_R0_BASE      = 3'd2,
    CFG_R0_PAGES     = 3'd3,
    CFG_R1_BASE      = 3'd4,
    CFG_R1_PAGES     = 3'd5
  } cfg_idx_t;

  // Request kinds.
  typedef enum logic {
    REQ_SET = 1'b0,
    REQ_GET = 1'b1
  } req_kind_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_ARG        = 3'd1,
    ST_UNALIGNED_ADDR = 3'd2,
    ST_UNALIGNED_SIZE = 3'd3,
    ST_NO_REGION      = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR    = 3'd0,
    S_IDLE     = 3'd1,
    S_LOCATE   = 3'd2,
    S_SETUP    = 3'd3,
    S_WRITE    = 3'd4,
    S_RD_ISSUE = 3'd5,
    S_RD_DATA  = 3'd6,
    S_FINISH   = 3'd7
  } state_t;

  // Input transaction.
  typedef struct packed {
    req_kind_t           req_type;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   size_bytes;
    logic [LEVEL_W-1:0]  level_mask;
    logic [ATTR_W-1:0]   new_attributes;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    status_t             status;
    logic [ATTR_W-1:0]   read_attributes;
  } out_item_t;

  // Global configuration seen by the controller.
  typedef struct packed {
    logic [SHIFT_W-1:0]  page_shift;
    logic [RCOUNT_W-1:0] region_count;
  } cfg_t;

  // Command from the controller to the attribute store.
  typedef struct packed {
    logic                we_user;
    logic                we_priv;
    logic                re;
    logic [ATTR_W-1:0]   wdata;
  } store_cmd_t;

endpackage

FILE: design/papt_cfg.sv
// ----------------------------------------------------------------------------
// Page attribute protection table configuration registers
// Holds the page shift, the region count and the base and length of each
// region slot, written through a plain write port.
// ----------------------------------------------------------------------------
module papt_cfg #(
  parameter int unsigned REGION_SLOTS = papt_pkg::REGION_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [papt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [papt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output papt_pkg::cfg_t                 cfg_o,
  output logic [papt_pkg::ADDR_W-1:0]     base_o  [REGION_SLOTS],
  output logic [papt_pkg::RPAGES_W-1:0]   pages_o [REGION_SLOTS]
);
  import papt_pkg::*;

  logic [SHIFT_W-1:0]  page_shift_r;
  logic [RCOUNT_W-1:0] region_count_r;
  logic [ADDR_W-1:0]   base_r  [REGION_SLOTS];
  logic [RPAGES_W-1:0] pages_r [REGION_SLOTS];

  // Global registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r   <= PAGE_SHIFT_RST;
      region_count_r <= REGION_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PAGE_SHIFT) begin
        page_shift_r <= cfg_wdata[SHIFT_W-1:0];
      end
      if (cfg_index == CFG_REGION_COUNT) begin
        region_count_r <= cfg_wdata[RCOUNT_W-1:0];
      end
    end
  end

  // Region slot registers. Only slots zero and one have register indexes;
  // any further slot keeps its reset value and never matches.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < REGION_SLOTS; s++) begin
        base_r[s]  <= '0;
        pages_r[s] <= '0;
      end
    end else if (cfg_we) begin
      for (int s = 0; s < REGION_SLOTS; s++) begin
        if ((s == 0 && cfg_index == CFG_R0_BASE) ||
            (s == 1 && cfg_index == CFG_R1_BASE)) begin
          base_r[s] <= cfg_wdata[ADDR_W-1:0];
        end
        if ((s == 0 && cfg_index == CFG_R0_PAGES) ||
            (s == 1 && cfg_index == CFG_R1_PAGES)) begin
          pages_r[s] <= cfg_wdata[RPAGES_W-1:0];
        end
      end
    end
  end

  assign cfg_o.page_shift   = page_shift_r;
  assign cfg_o.region_count = region_count_r;
  assign base_o             = base_r;
  assign pages_o            = pages_r;

endmodule

FILE: design/papt_store.sv
// ----------------------------------------------------------------------------
// Page attribute protection table store
// Two synchronous memories, one per privilege level, with one shared
// address, per-level write enables and a registered read.
// ----------------------------------------------------------------------------
module papt_store #(
  parameter int unsigned DEPTH   = papt_pkg::REGION_SLOTS_DEF * papt_pkg::PAGES_PER_REGION_DEF,
  parameter int unsigned DEPTH_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  papt_pkg::store_cmd_t         cmd_i,
  input  logic [DEPTH_W-1:0]           addr_i,
  output logic [papt_pkg::ATTR_W-1:0]  rdata_user_o,
  output logic [papt_pkg::ATTR_W-1:0]  rdata_priv_o
);
  import papt_pkg::*;

  logic [ATTR_W-1:0] mem_user [DEPTH];
  logic [ATTR_W-1:0] mem_priv [DEPTH];
  logic [ATTR_W-1:0] rdata_user_r;
  logic [ATTR_W-1:0] rdata_priv_r;

  // User level memory.
  always_ff @(posedge clk) begin
    if (cmd_i.we_user) begin
      mem_user[addr_i] <= cmd_i.wdata;
    end
    if (cmd_i.re) begin
      rdata_user_r <= mem_user[addr_i];
    end
  end

  // Privileged level memory.
  always_ff @(posedge clk) begin
    if (cmd_i.we_priv) begin
      mem_priv[addr_i] <= cmd_i.wdata;
    end
    if (cmd_i.re) begin
      rdata_priv_r <= mem_priv[addr_i];
    end
  end

  assign rdata_user_o = rdata_user_r;
  assign rdata_priv_o = rdata_priv_r;

endmodule

FILE: design/papt_ctrl.sv
// ----------------------------------------------------------------------------
// Page attribute protection table controller
// Checks each request, searches the region slots one per cycle, then
// writes the page range or reads one page through the attribute store.
// Also runs the clearing pass after reset and holds the result register.
// ----------------------------------------------------------------------------
module papt_ctrl #(
  parameter int unsigned REGION_SLOTS     = papt_pkg::REGION_SLOTS_DEF,
  parameter int unsigned PAGES_PER_REGION = papt_pkg::PAGES_PER_REGION_DEF,
  parameter int unsigned DEPTH            = REGION_SLOTS * PAGES_PER_REGION,
  parameter int unsigned DEPTH_W          = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  papt_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output papt_pkg::out_item_t          out_data,
  input  papt_pkg::cfg_t               cfg_i,
  input  logic [papt_pkg::ADDR_W-1:0]   base_i  [REGION_SLOTS],
  input  logic [papt_pkg::RPAGES_W-1:0] pages_i [REGION_SLOTS],
  output papt_pkg::store_cmd_t         cmd_o,
  output logic [DEPTH_W-1:0]           addr_o,
  input  logic [papt_pkg::ATTR_W-1:0]   rdata_user_i,
  input  logic [papt_pkg::ATTR_W-1:0]   rdata_priv_i
);
  import papt_pkg::*;

  // Derived widths.
  localparam int unsigned SLOT_W  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int unsigned SCNT_W  = $clog2(REGION_SLOTS + 1);
  localparam int unsigned PAGE_W  = $clog2(PAGES_PER_REGION);
  localparam int unsigned PCNT_RAW = $clog2(PAGES_PER_REGION + 1);
  localparam int unsigned PCNT_W  = (PCNT_RAW > RPAGES_W) ? PCNT_RAW : RPAGES_W;
  localparam int unsigned END_W   = PCNT_W + ADDR_W;

  state_t              state_r, state_nxt;
  logic [DEPTH_W-1:0]  clr_r, clr_nxt;
  req_kind_t           kind_r, kind_nxt;
  logic [ADDR_W-1:0]   start_r, start_nxt;
  logic [ADDR_W:0]     end_r, end_nxt;
  logic [PCNT_W-1:0]   npg_r, npg_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [ATTR_W-1:0]   attr_r, attr_nxt;
  status_t             status_r, status_nxt;
  logic [SCNT_W-1:0]   slot_r, slot_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [PCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ATTR_W-1:0]   rd_r, rd_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // Shared combinational terms.
  logic [ADDR_W-1:0]   mask;
  logic [ADDR_W-1:0]   pbytes;
  logic [ADDR_W-1:0]   op_start;
  logic [ADDR_W-1:0]   op_size;
  status_t             chk_status;
  logic [SCNT_W-1:0]   slot_lim;
  logic [SLOT_W-1:0]   sidx;
  logic [ADDR_W-1:0]   slot_base;
  logic [PCNT_W-1:0]   slot_pages;
  logic [END_W-1:0]    slot_end;
  logic                slot_hit;
  logic [ADDR_W-1:0]   offset;
  logic                accept;

  assign accept = in_valid && !in_stall;
  assign mask   = (ADDR_W'(1) << cfg_i.page_shift) - ADDR_W'(1);
  assign pbytes = ADDR_W'(1) << cfg_i.page_shift;
  assign sidx   = slot_r[SLOT_W-1:0];

  // Request checks at acceptance. A get is turned into a one-page range.
  always_comb begin
    if (in_data.req_type == REQ_SET) begin
      op_start = in_data.address;
      op_size  = in_data.size_bytes;
      if (in_data.size_bytes == '0) begin
        chk_status = ST_BAD_ARG;
      end else if ((in_data.address & mask) != '0) begin
        chk_status = ST_UNALIGNED_ADDR;
      end else if ((in_data.size_bytes & mask) != '0) begin
        chk_status = ST_UNALIGNED_SIZE;
      end else begin
        chk_status = ST_OK;
      end
    end else begin
      op_start = in_data.address & ~mask;
      op_size  = pbytes;
      if (in_data.level_mask == LVL_USER || in_data.level_mask == LVL_PRIV) begin
        chk_status = ST_OK;
      end else begin
        chk_status = ST_BAD_ARG;
      end
    end
  end

  // Region slot under test: saturated count and length, end without wrap.
  always_comb begin
    if (32'(cfg_i.region_count) > REGION_SLOTS) begin
      slot_lim = SCNT_W'(REGION_SLOTS);
    end else begin
      slot_lim = SCNT_W'(cfg_i.region_count);
    end
    if (32'(pages_i[sidx]) > PAGES_PER_REGION) begin
      slot_pages = PCNT_W'(PAGES_PER_REGION);
    end else begin
      slot_pages = PCNT_W'(pages_i[sidx]);
    end
    slot_base = base_i[sidx] & ~mask;
    slot_end  = END_W'(slot_base) + (END_W'(slot_pages) << cfg_i.page_shift);
    slot_hit  = (start_r >= slot_base) && (END_W'(end_r) <= slot_end);
  end

  assign offset = start_r - base_r;

  // Next state, datapath updates and store commands.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    kind_nxt      = kind_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    npg_nxt       = npg_r;
    level_nxt     = level_r;
    attr_nxt      = attr_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    base_nxt      = base_r;
    page_nxt      = page_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd_o         = '0;
    addr_o        = DEPTH_W'(sidx) * DEPTH_W'(PAGES_PER_REGION) + DEPTH_W'(page_r);

    unique case (state_r)
      S_CLEAR: begin
        // Zero one entry of both levels per cycle.
        cmd_o.we_user = 1'b1;
        cmd_o.we_priv = 1'b1;
        addr_o        = clr_r;
        clr_nxt       = clr_r + DEPTH_W'(1);
        if (clr_r == DEPTH_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          kind_nxt   = in_data.req_type;
          start_nxt  = op_start;
          end_nxt    = {1'b0, op_start} + {1'b0, op_size};
          npg_nxt    = (in_data.req_type == REQ_SET) ?
                       PCNT_W'(in_data.size_bytes >> cfg_i.page_shift) : PCNT_W'(1);
          level_nxt  = in_data.level_mask;
          attr_nxt   = in_data.new_attributes;
          status_nxt = chk_status;
          slot_nxt   = '0;
          rd_nxt     = '0;
          state_nxt  = (chk_status == ST_OK) ? S_LOCATE : S_FINISH;
        end
      end
      S_LOCATE: begin
        // One region slot per cycle, first match wins.
        if (slot_r >= slot_lim) begin
          status_nxt = ST_NO_REGION;
          state_nxt  = S_FINISH;
        end else if (slot_hit) begin
          base_nxt  = slot_base;
          state_nxt = S_SETUP;
        end else begin
          slot_nxt = slot_r + SCNT_W'(1);
        end
      end
      S_SETUP: begin
        page_nxt = PAGE_W'(offset >> cfg_i.page_shift);
        cnt_nxt  = npg_r;
        if (kind_r == REQ_GET) begin
          state_nxt = S_RD_ISSUE;
        end else if (level_r == LVL_NONE) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        // One page per cycle at each selected level.
        cmd_o.we_user = level_r[0];
        cmd_o.we_priv = level_r[1];
        cmd_o.wdata   = attr_r;
        page_nxt      = page_r + PAGE_W'(1);
        cnt_nxt       = cnt_r - PCNT_W'(1);
        if (cnt_r == PCNT_W'(1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_RD_ISSUE: begin
        cmd_o.re  = 1'b1;
        state_nxt = S_RD_DATA;
      end
      S_RD_DATA: begin
        rd_nxt    = (level_r == LVL_PRIV) ? rdata_priv_i : rdata_user_i;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // Load the result register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = status_r;
          out_data_nxt.read_attributes = rd_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Transaction payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    npg_r      <= npg_nxt;
    level_r    <= level_nxt;
    attr_r     <= attr_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    base_r     <= base_nxt;
    page_r     <= page_nxt;
    cnt_r      <= cnt_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // An accepted transaction always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted transaction did not start processing");

  // The store is written only by the clearing pass or a range write.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_o.we_user || cmd_o.we_priv) |-> (state_r == S_CLEAR || state_r == S_WRITE))
    else $error("store written outside clearing or range write");

  // A range write never runs with an exhausted page count.
  a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |-> cnt_r != '0)
    else $error("range write with zero remaining pages");

  // Only a successful get returns a nonzero attribute.
  a_error_zero_attr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status == ST_OK || out_data_r.read_attributes == '0))
    else $error("failed request returned a nonzero attribute");
`endif

endmodule

FILE: design/page_attribute_protection_table.sv
// ----------------------------------------------------------------------------
// Page attribute protection table
// Per-page 4-bit attributes for user and privileged level over up to two
// configured memory regions, with range set and single page get requests.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   in_data  (papt_pkg::in_item_t)
// out      out  out_valid / out_stall out_data (papt_pkg::out_item_t)
// cfg      in   cfg_we                cfg_index, cfg_wdata
//
// A set searches the region slots one per cycle, then writes its pages,
// one per cycle through the store write port; a get searches the slots,
// then reads its page through the registered store read. Errors found at
// acceptance skip the search. After reset a clearing pass zeroes all
// REGION_SLOTS * PAGES_PER_REGION entries of the store (512 by default),
// one entry per cycle, with in_stall high. A new request is taken while a
// result waits in the output register; a stalled output holds the
// controller before its next result.
// ----------------------------------------------------------------------------
module page_attribute_protection_table #(
  parameter int unsigned REGION_SLOTS     = papt_pkg::REGION_SLOTS_DEF,
  parameter int unsigned PAGES_PER_REGION = papt_pkg::PAGES_PER_REGION_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  papt_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output papt_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [papt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [papt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import papt_pkg::*;

  localparam int unsigned DEPTH   = REGION_SLOTS * PAGES_PER_REGION;
  localparam int unsigned DEPTH_W = $clog2(DEPTH);

  cfg_t                cfg;
  logic [ADDR_W-1:0]   base  [REGION_SLOTS];
  logic [RPAGES_W-1:0] pages [REGION_SLOTS];
  store_cmd_t          cmd;
  logic [DEPTH_W-1:0]  store_addr;
  logic [ATTR_W-1:0]   rdata_user;
  logic [ATTR_W-1:0]   rdata_priv;

  // Configuration registers.
  papt_cfg #(
    .REGION_SLOTS (REGION_SLOTS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg),
    .base_o    (base),
    .pages_o   (pages)
  );

  // Attribute memories.
  papt_store #(
    .DEPTH   (DEPTH),
    .DEPTH_W (DEPTH_W)
  ) u_store (
    .clk          (clk),
    .cmd_i        (cmd),
    .addr_i       (store_addr),
    .rdata_user_o (rdata_user),
    .rdata_priv_o (rdata_priv)
  );

  // Request sequencer and result register.
  papt_ctrl #(
    .REGION_SLOTS     (REGION_SLOTS),
    .PAGES_PER_REGION (PAGES_PER_REGION),
    .DEPTH            (DEPTH),
    .DEPTH_W          (DEPTH_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_i        (cfg),
    .base_i       (base),
    .pages_i      (pages),
    .cmd_o        (cmd),
    .addr_o       (store_addr),
    .rdata_user_i (rdata_user),
    .rdata_priv_i (rdata_priv)
  );

endmodule

FILE: tb/tb_page_attribute_protection_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page attribute protection table testbench
// Sets and reads back per-page attributes over several region layouts and
// page sizes. Each accepted request is run through a local model of the
// attribute store, and every result transaction is compared field by field
// with the oldest prediction. The input channel idles and the output channel stalls at random.
// ----------------------------------------------------------------------------
module tb_page_attribute_protection_table;
  import papt_pkg::*;

  localparam int unsigned PAGES       = PAGES_PER_REGION_DEF;
  localparam int unsigned STORE_DEPTH = REGION_SLOTS_DEF * 2 * PAGES_PER_REGION_DEF;
  localparam int          PHASE_ITEMS = 80;

  // Register indexes that are not mapped to any register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the configuration and of the attribute store.
  logic [SHIFT_W-1:0]  shift_cfg;
  logic [RCOUNT_W-1:0] count_cfg;
  logic [ADDR_W-1:0]   base_cfg [REGION_SLOTS_DEF];
  logic [RPAGES_W-1:0] pages_cfg [REGION_SLOTS_DEF];
  logic [ATTR_W-1:0]   attr_mem [STORE_DEPTH];

  in_item_t  pending_requests [$];
  out_item_t expected_results [$];
  int        mismatch_count = 0;
  logic      in_accepted = 1'b0;
  logic      no_idle = 1'b0;
  int        hold_left = 0;
  int        stall_left = 0;

  page_attribute_protection_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Region geometry as the block sees it.
  function automatic logic [63:0] page_span();
    return 64'd1 << shift_cfg;
  endfunction

  function automatic logic [63:0] region_start(int slot);
    return 64'(base_cfg[slot]) & ~(page_span() - 64'd1);
  endfunction

  function automatic int region_pages(int slot);
    return (pages_cfg[slot] > PAGES) ? PAGES : int'(pages_cfg[slot]);
  endfunction

  function automatic int store_slot(int slot, int lv, logic [63:0] page);
    logic [63:0] idx;
    idx = (64'(slot) * 2 + 64'(lv)) * PAGES + page;
    return (idx < STORE_DEPTH) ? int'(idx) : 0;
  endfunction

  // Size and alignment checks, then the first region that holds the range.
  function automatic status_t locate_range(logic [63:0] start, logic [63:0] len,
                                           output int slot);
    logic [63:0] msk;
    logic [63:0] b;
    logic [63:0] e;
    int          cnt;
    int          s;
    msk = page_span() - 64'd1;
    cnt = (count_cfg > REGION_SLOTS_DEF) ? REGION_SLOTS_DEF : int'(count_cfg);
    slot = 0;
    if (len == 0) return ST_BAD_ARG;
    if ((start & msk) != 0) return ST_UNALIGNED_ADDR;
    if ((len & msk) != 0) return ST_UNALIGNED_SIZE;
    for (s = 0; s < cnt; s++) begin
      b = region_start(s);
      e = b + (64'(region_pages(s)) << shift_cfg);
      if (start >= b && start + len <= e) begin
        slot = s;
        return ST_OK;
      end
    end
    return ST_NO_REGION;
  endfunction

  // Applies one request to the local store and returns the expected result.
  function automatic out_item_t predict_access(in_item_t it);
    out_item_t   res;
    logic [63:0] first;
    logic [63:0] n;
    logic [63:0] k;
    logic [63:0] pstart;
    int          slot;
    int          lv;
    res.status = ST_OK;
    res.read_attributes = '0;
    if (it.req_type == REQ_SET) begin
      res.status = locate_range(64'(it.address), 64'(it.size_bytes), slot);
      if (res.status == ST_OK) begin
        first = (64'(it.address) - region_start(slot)) >> shift_cfg;
        n = 64'(it.size_bytes) >> shift_cfg;
        for (k = 0; k < n; k++) begin
          for (lv = 0; lv < 2; lv++) begin
            if (it.level_mask[lv]) attr_mem[store_slot(slot, lv, first + k)] = it.new_attributes;
          end
        end
      end
    end else if (it.level_mask != LVL_USER && it.level_mask != LVL_PRIV) begin
      res.status = ST_BAD_ARG;
    end else begin
      pstart = 64'(it.address) & ~(page_span() - 64'd1);
      res.status = locate_range(pstart, page_span(), slot);
      if (res.status == ST_OK) begin
        res.read_attributes = attr_mem[store_slot(slot, (it.level_mask == LVL_USER) ? 0 : 1,
                                                  (pstart - region_start(slot)) >> shift_cfg)];
      end
    end
    return res;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_length();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic in_item_t pack_request(req_kind_t kind, logic [31:0] addr,
                                            logic [31:0] size, logic [1:0] lvl,
                                            logic [3:0] attr);
    in_item_t it;
    it.req_type = kind;
    it.address = addr;
    it.size_bytes = size;
    it.level_mask = lvl;
    it.new_attributes = attr;
    return it;
  endfunction

  // Random request. Most hit a configured region with aligned, in-range
  // values; the rest are fully random or slightly broken.
  function automatic in_item_t make_request();
    in_item_t    it;
    logic [63:0] base;
    int          pick;
    int          slot;
    int          span;
    int          first;
    int          n;
    it = pack_request($urandom_range(0, 1) ? REQ_GET : REQ_SET, $urandom, $urandom,
                      2'($urandom), 4'($urandom));
    pick = $urandom_range(0, 99);
    slot = (count_cfg >= 2) ? $urandom_range(0, 1) : 0;
    span = region_pages(slot);
    if (pick < 20 || span == 0) return it;
    base = region_start(slot);
    first = $urandom_range(0, span - 1);
    if (it.req_type == REQ_SET) begin
      if (pick < 85) begin
        n = $urandom_range(1, 4);
        if (n > span - first) n = span - first;
      end else begin
        n = $urandom_range(1, span - first);
      end
      it.address = 32'(base + (64'(first) << shift_cfg));
      it.size_bytes = 32'(64'(n) << shift_cfg);
      if (pick < 30) begin
        if ($urandom_range(0, 1)) it.address += $urandom_range(1, 3);
        else it.size_bytes += $urandom_range(1, 3);
      end
    end else begin
      it.address = 32'(base + (64'(first) << shift_cfg) +
                       (64'($urandom) & (page_span() - 64'd1)));
      if (pick >= 30) it.level_mask = $urandom_range(0, 1) ? LVL_USER : LVL_PRIV;
    end
    return it;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  // One register write; the local copy follows at once since the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PAGE_SHIFT:   shift_cfg = val[SHIFT_W-1:0];
      CFG_REGION_COUNT: count_cfg = val[RCOUNT_W-1:0];
      CFG_R0_BASE:      base_cfg[0] = val;
      CFG_R0_PAGES:     pages_cfg[0] = val[RPAGES_W-1:0];
      CFG_R1_BASE:      base_cfg[1] = val;
      CFG_R1_PAGES:     pages_cfg[1] = val[RPAGES_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register; unused upper data bits carry random values.
  task automatic configure(input logic [4:0] shift, input logic [1:0] count,
                           input logic [31:0] b0, input logic [8:0] p0,
                           input logic [31:0] b1, input logic [8:0] p1);
    write_reg(CFG_PAGE_SHIFT, {27'($urandom), shift});
    write_reg(CFG_REGION_COUNT, {30'($urandom), count});
    write_reg(CFG_R0_BASE, b0);
    write_reg(CFG_R0_PAGES, {23'($urandom), p0});
    write_reg(CFG_R1_BASE, b1);
    write_reg(CFG_R1_PAGES, {23'($urandom), p1});
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued transaction has been driven and answered. The
  // check runs just after the falling edge, once the driver has settled.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Request driver: presents queued transactions with random gaps between them.
  always @(negedge clk) begin : request_driver
    if (!in_valid || in_accepted) begin
      if (hold_left > 0) begin
        in_valid <= 1'b0;
        hold_left--;
      end else if (pending_requests.size() != 0) begin
        in_data <= pending_requests.pop_front();
        in_valid <= 1'b1;
        hold_left = idle_length();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: stalls the output channel for random stretches.
  always @(negedge clk) begin : result_sink
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = ($urandom_range(0, 3) == 0) ? idle_length() : 0;
    end
  end

  // Monitor: checks each result transaction, then predicts for each request taken.
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_accepted <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_error($sformatf("Unexpected result: status %0d, attributes %0h",
                             out_data.status, out_data.read_attributes));
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          flag_error($sformatf("Status mismatch: expected %0d, got %0d",
                               want.status, out_data.status));
        if (out_data.read_attributes !== want.read_attributes)
          flag_error($sformatf("Attribute mismatch: expected %0h, got %0h",
                               want.read_attributes, out_data.read_attributes));
      end
    end
    if (rst_n && in_valid && !in_stall) expected_results.push_back(predict_access(in_data));
  end

  // Stimulus: directed checks first, then random phases, each under its own layout.
  initial begin : stimulus
    int phase;
    shift_cfg = PAGE_SHIFT_RST;
    count_cfg = REGION_COUNT_RST;
    foreach (base_cfg[i]) base_cfg[i] = '0;
    foreach (pages_cfg[i]) pages_cfg[i] = '0;
    foreach (attr_mem[i]) attr_mem[i] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // Let the clearing pass of the store run to its end.
    @(posedge clk);
    while (!in_stall) @(posedge clk);
    while (in_stall) @(posedge clk);

    // Sixteen pages in region zero, a full region one.
    configure(5'd12, 2'd2, 32'h1000_0000, 9'd16, 32'h2000_0000, 9'd256);
    pending_requests.push_back(pack_request(REQ_GET, 32'h1000_0000, 32'h0, LVL_USER, 4'h0));
    pending_requests.push_back(pack_request(REQ_SET, 32'h1000_0000, 32'h0, 2'b11, 4'hF));
    pending_requests.push_back(pack_request(REQ_SET, 32'h1000_0004, 32'h1000, 2'b11, 4'hF));
    pending_requests.push_back(pack_request(REQ_SET, 32'h1000_0000, 32'h1001, 2'b11, 4'hF));
    pending_requests.push_back(pack_request(REQ_SET, 32'h0, 32'h1000, 2'b11, 4'h3));
    pending_requests.push_back(pack_request(REQ_SET, 32'h1000_0000, 32'h1_0000, 2'b11, 4'hF));
    pending_requests.push_back(pack_request(REQ_GET, 32'h1000_FFFF, 32'hFFFF_FFFF, LVL_USER, 4'h0));
    pending_requests.push_back(pack_request(REQ_GET, 32'h1000_0000, 32'h0, LVL_PRIV, 4'hF));
    pending_requests.push_back(pack_request(REQ_GET, 32'h1000_0000, 32'h0, LVL_NONE, 4'h0));
    pending_requests.push_back(pack_request(REQ_GET, 32'h1000_0000, 32'h0, 2'b11, 4'h0));
    // Empty level mask on a valid range writes nothing.
    pending_requests.push_back(pack_request(REQ_SET, 32'h1000_2000, 32'h1000, LVL_NONE, 4'h5));
    pending_requests.push_back(pack_request(REQ_GET, 32'h1000_2000, 32'h0, LVL_USER, 4'h0));
    pending_requests.push_back(pack_request(REQ_SET, 32'h1000_3000, 32'h2000, LVL_USER, 4'h0));
    pending_requests.push_back(pack_request(REQ_GET, 32'h1000_3ABC, 32'h0, LVL_USER, 4'h0));
    pending_requests.push_back(pack_request(REQ_GET, 32'h1000_4000, 32'h0, LVL_PRIV, 4'h0));
    pending_requests.push_back(pack_request(REQ_SET, 32'h2000_0000, 32'h10_0000, LVL_PRIV, 4'hA));
    pending_requests.push_back(pack_request(REQ_GET, 32'h200F_F000, 32'h0, LVL_PRIV, 4'h0));
    pending_requests.push_back(pack_request(REQ_GET, 32'h200F_FFFF, 32'h0, LVL_USER, 4'h0));
    // Range past the end of a region, and ranges past the top of memory.
    pending_requests.push_back(pack_request(REQ_SET, 32'h1000_F000, 32'h2000, 2'b11, 4'h1));
    pending_requests.push_back(pack_request(REQ_SET, 32'hFFFF_F000, 32'h2000, 2'b11, 4'h1));
    pending_requests.push_back(pack_request(REQ_GET, 32'hFFFF_FFFF, 32'h0, LVL_USER, 4'h0));
    pending_requests.push_back(pack_request(REQ_SET, 32'h1000_0000, 32'hFFFF_FFFF, 2'b11, 4'h2));
    pending_requests.push_back(pack_request(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11, 4'hF));
    pending_requests.push_back(pack_request(REQ_GET, 32'h0, 32'h0, LVL_PRIV, 4'h0));

    for (phase = 0; phase < 8; phase++) begin
      wait_drained();
      no_idle = (phase == 2 || phase == 5);
      case (phase)
        0: configure(5'd0, 2'd2, $urandom, 9'($urandom_range(1, 256)), $urandom,
                     9'($urandom_range(1, 256)));
        1: configure(5'd20, 2'd3, $urandom, 9'd511, $urandom, 9'($urandom_range(0, 256)));
        2: configure(5'd31, 2'd1, $urandom, 9'($urandom_range(1, 4)), 32'h0, 9'd0);
        3: configure(5'($urandom_range(0, 20)), 2'd0, $urandom, 9'd256, $urandom, 9'd256);
        4: begin
          // Both regions start at the same base, so the first one wins.
          base_cfg[0] = $urandom;
          configure(5'($urandom_range(0, 20)), 2'd2, base_cfg[0], 9'($urandom_range(1, 64)),
                    base_cfg[0], 9'($urandom_range(1, 256)));
        end
        5: configure(5'd12, 2'd2, 32'hFFFF_FFFF, 9'd256, 32'h0, 9'($urandom_range(1, 256)));
        default: configure(5'($urandom_range(0, 20)), 2'($urandom_range(1, 2)), $urandom,
                           9'($urandom), $urandom, 9'($urandom));
      endcase
      repeat ((phase == 3) ? 30 : PHASE_ITEMS) pending_requests.push_back(make_request());
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatch_count + expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit.
  initial begin : watchdog
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
design/papt_pkg.sv
design/papt_cfg.sv
design/papt_store.sv
design/papt_ctrl.sv
design/page_attribute_protection_table.sv
tb/tb_page_attribute_protection_table.sv
